/* src/tcf_pkg.sv */
`timescale 1ns / 1ps

package tcf_pkg;

  // Iteration count of the vectoring CORDIC
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;
  localparam int ATAN_IDX_W = 5;

  // Field and register widths
  localparam int SMP_W    = 16;
  localparam int FILT_W   = 24;
  localparam int POS_W    = 2;
  localparam int WEIGHT_W = 17;
  localparam int GAIN_W   = 24;
  localparam int THR_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Datapath widths
  localparam int CW      = 19;              // CORDIC x / y
  localparam int ANG_W   = 25;              // angle, Q16 degrees
  localparam int ACC_W   = ANG_W - 8;       // accelerometer angle, Q8 degrees
  localparam int INCR_W  = 25;              // gyro increment, Q8 degrees
  localparam int SUM_W   = 26;              // filtered angle plus increment
  localparam int FRAC_W  = 16;              // Q16 scaling of both products
  localparam int MCAND_W = 27;              // serial multiplier, multiplicand
  localparam int MPLR_W  = 18;              // serial multiplier, multiplier bits
  localparam int PROD_W  = MCAND_W + 1 + MPLR_W;
  localparam int NV_W    = PROD_W - FRAC_W + 1;

  localparam logic signed [ANG_W-1:0] ANG_90     = ANG_W'(5898240);
  localparam logic [WEIGHT_W-1:0]     WEIGHT_ONE = WEIGHT_W'(65536);
  localparam logic signed [NV_W-1:0]  NV_MAX     = NV_W'(8388607);
  localparam logic signed [NV_W-1:0]  NV_MIN     = ~NV_MAX;

  // Register reset values
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(2621);
  localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(128074);
  localparam logic [THR_W-1:0]    THR_RST    = THR_W'(9);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_WEIGHT = 2'd0,
    CFG_GYRO_GAIN    = 2'd1,
    CFG_THRESHOLD    = 2'd2
  } cfg_idx_e;

  typedef enum logic [POS_W-1:0] {
    POS_CENTER = 2'd0,
    POS_RIGHT  = 2'd1,
    POS_LEFT   = 2'd2
  } pos_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_SUM,
    ST_MIX_START,
    ST_MIX,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [SMP_W-1:0] accel_x;
    logic signed [SMP_W-1:0] accel_z;
    logic signed [SMP_W-1:0] gyro_y;
  } in_t;

  typedef struct packed {
    logic signed [FILT_W-1:0] tilt_angle;
    logic [POS_W-1:0]         position;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [ANG_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = ANG_W'(2949120);
      5'd1:  v = ANG_W'(1740967);
      5'd2:  v = ANG_W'(919879);
      5'd3:  v = ANG_W'(466945);
      5'd4:  v = ANG_W'(234379);
      5'd5:  v = ANG_W'(117304);
      5'd6:  v = ANG_W'(58666);
      5'd7:  v = ANG_W'(29335);
      5'd8:  v = ANG_W'(14668);
      5'd9:  v = ANG_W'(7334);
      5'd10: v = ANG_W'(3667);
      5'd11: v = ANG_W'(1833);
      5'd12: v = ANG_W'(917);
      5'd13: v = ANG_W'(458);
      5'd14: v = ANG_W'(229);
      5'd15: v = ANG_W'(115);
      5'd16: v = ANG_W'(57);
      5'd17: v = ANG_W'(29);
      5'd18: v = ANG_W'(14);
      5'd19: v = ANG_W'(7);
      5'd20: v = ANG_W'(4);
      5'd21: v = ANG_W'(2);
      5'd22: v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/tcf_serial_mul.sv */
`timescale 1ns / 1ps

// Shift-add multiplier: one multiplier bit per cycle, LSB first, two's complement
// multiplier (the last bit carries negative weight).
module tcf_serial_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [tcf_pkg::MCAND_W-1:0]   mcand_i,
  input  logic [tcf_pkg::MPLR_W-1:0]           mplr_i,
  output logic [tcf_pkg::PROD_W-1:0]           prod_o,
  output tcf_pkg::mul_stat_t                   stat_o
);

  localparam int CNT_W = $clog2(tcf_pkg::MPLR_W);
  localparam int HI_W  = tcf_pkg::MCAND_W + 1;

  logic [tcf_pkg::MCAND_W-1:0] mcand_q;
  logic signed [HI_W-1:0]      hi_q, hi_d;
  logic [tcf_pkg::MPLR_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q, done_q;
  logic                        last;
  logic signed [HI_W-1:0]      mc_ext, addend, sum;

  // Add or subtract the multiplicand for the current bit, then shift right
  always_comb begin
    last   = (cnt_q == CNT_W'(tcf_pkg::MPLR_W - 1));
    mc_ext = {mcand_q[tcf_pkg::MCAND_W-1], mcand_q};
    if (!lo_q[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -mc_ext;
    end else begin
      addend = mc_ext;
    end
    sum  = hi_q + addend;
    hi_d = sum >>> 1;
    lo_d = {sum[0], lo_q[tcf_pkg::MPLR_W-1:1]};
  end

  // Control: count multiplier bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath: load operands, then advance one bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplr_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign prod_o      = {hi_q, lo_q};
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

/* src/tilt_complementary_filter_classifier.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake                    Payload
// in       input      in_valid_i / in_ready_o      in_data_i  (accel_x, accel_z, gyro_y)
// out      output     out_valid_o / out_ready_i    out_data_o (tilt_angle, position)
// cfg      input      cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// Per item, the iterative CORDIC runs beside the serial gyro product, then a second
// serial product mixes the angles. One item is in flight; the result register lets
// the next item start while a result still waits on out_ready_i. Reset clears the
// angle, position and registers to their reset values. Configuration transfers are
// always taken.
module tilt_complementary_filter_classifier #(
  parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tcf_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tcf_pkg::out_t                      out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tcf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
  localparam int CW     = tcf_pkg::CW;
  localparam int ANG_W  = tcf_pkg::ANG_W;
  localparam int SMP_W  = tcf_pkg::SMP_W;
  localparam int FILT_W = tcf_pkg::FILT_W;
  localparam int SUM_W  = tcf_pkg::SUM_W;
  localparam int INCR_W = tcf_pkg::INCR_W;
  localparam int ACC_W  = tcf_pkg::ACC_W;
  localparam int FRAC_W = tcf_pkg::FRAC_W;
  localparam int PROD_W = tcf_pkg::PROD_W;
  localparam int NV_W   = tcf_pkg::NV_W;
  localparam int MCAND_W = tcf_pkg::MCAND_W;
  localparam int MPLR_W  = tcf_pkg::MPLR_W;

  tcf_pkg::state_e state_q, state_d;

  // Configuration registers
  logic [tcf_pkg::WEIGHT_W-1:0] weight_q;
  logic [tcf_pkg::GAIN_W-1:0]   gain_q;
  logic [tcf_pkg::THR_W-1:0]    thr_q;

  // Filter state and result register
  logic signed [FILT_W-1:0] filt_q;
  tcf_pkg::pos_e            pos_q, pos_d;
  tcf_pkg::out_t            out_q;
  logic                     out_valid_q;

  // CORDIC
  logic signed [CW-1:0]    x_q, y_q, x0, y0, dx, dy, ax_w, az_w;
  logic signed [ANG_W-1:0] ang_q, ang0, atan_v, ang_rnd;
  logic [STEP_W-1:0]       cstep_q;
  logic                    zero_q, cordic_done;

  // Mixing path
  logic signed [INCR_W-1:0] incr_q, incr_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [SUM_W-1:0]  s_q;
  logic signed [NV_W-1:0]   nv_wide;
  logic signed [FILT_W-1:0] nv_q, nv_sat;
  logic signed [FILT_W-1:0] thr_s;
  logic [tcf_pkg::WEIGHT_W-1:0] alpha;

  // Multiplier hookup
  logic                       mul_start;
  logic signed [MCAND_W-1:0]  mul_mcand;
  logic [MPLR_W-1:0]          mul_mplr;
  logic [PROD_W-1:0]          prod;
  tcf_pkg::mul_stat_t         mul_stat;

  // FSM outputs
  logic in_fire, out_free, cordic_en, run_exit, sum_en, fin_en, out_load, mix_sel;

  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cordic_done = (cstep_q == STEP_W'(CORDIC_STEPS));
  assign cfg_ready_o = 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcf_pkg::ST_IDLE:      if (in_valid_i) state_d = tcf_pkg::ST_RUN;
      tcf_pkg::ST_RUN:       if (cordic_done && !mul_stat.busy) state_d = tcf_pkg::ST_SUM;
      tcf_pkg::ST_SUM:       state_d = tcf_pkg::ST_MIX_START;
      tcf_pkg::ST_MIX_START: state_d = tcf_pkg::ST_MIX;
      tcf_pkg::ST_MIX:       if (!mul_stat.busy) state_d = tcf_pkg::ST_FIN;
      tcf_pkg::ST_FIN:       state_d = tcf_pkg::ST_OUT;
      tcf_pkg::ST_OUT:       if (out_free) state_d = tcf_pkg::ST_IDLE;
      default:               state_d = tcf_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    cordic_en  = 1'b0;
    run_exit   = 1'b0;
    sum_en     = 1'b0;
    mix_sel    = 1'b0;
    fin_en     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      tcf_pkg::ST_IDLE:      in_ready_o = 1'b1;
      tcf_pkg::ST_RUN: begin
        cordic_en = !cordic_done;
        run_exit  = cordic_done && !mul_stat.busy;
      end
      tcf_pkg::ST_SUM:       sum_en = 1'b1;
      tcf_pkg::ST_MIX_START: mix_sel = 1'b1;
      tcf_pkg::ST_MIX:       ;
      tcf_pkg::ST_FIN:       fin_en = 1'b1;
      tcf_pkg::ST_OUT:       out_load = out_free;
      default:               ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= tcf_pkg::WEIGHT_RST;
      gain_q   <= tcf_pkg::GAIN_RST;
      thr_q    <= tcf_pkg::THR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tcf_pkg::CFG_ACCEL_WEIGHT: weight_q <= cfg_data_i[tcf_pkg::WEIGHT_W-1:0];
        tcf_pkg::CFG_GYRO_GAIN:    gain_q   <= cfg_data_i[tcf_pkg::GAIN_W-1:0];
        tcf_pkg::CFG_THRESHOLD:    thr_q    <= cfg_data_i[tcf_pkg::THR_W-1:0];
        default:                   ;
      endcase
    end
  end

  // Pre-rotate a vector with negative Z into the right half plane
  always_comb begin
    ax_w = {{(CW-SMP_W){in_data_i.accel_x[SMP_W-1]}}, in_data_i.accel_x};
    az_w = {{(CW-SMP_W){in_data_i.accel_z[SMP_W-1]}}, in_data_i.accel_z};
    if (!az_w[CW-1]) begin
      x0 = az_w;  y0 = ax_w;  ang0 = '0;
    end else if (!ax_w[CW-1]) begin
      x0 = ax_w;  y0 = -az_w; ang0 = tcf_pkg::ANG_90;
    end else begin
      x0 = -ax_w; y0 = az_w;  ang0 = -tcf_pkg::ANG_90;
    end
  end

  // One CORDIC micro-rotation per cycle
  always_comb begin
    dx     = y_q >>> cstep_q;
    dy     = x_q >>> cstep_q;
    atan_v = tcf_pkg::atan_q16(tcf_pkg::ATAN_IDX_W'(cstep_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cstep_q <= '0;
    end else if (in_fire) begin
      cstep_q <= '0;
    end else if (cordic_en) begin
      cstep_q <= cstep_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q    <= x0;
      y_q    <= y0;
      ang_q  <= ang0;
      zero_q <= (in_data_i.accel_x == '0) && (in_data_i.accel_z == '0);
    end else if (cordic_en) begin
      if (!y_q[CW-1]) begin
        x_q   <= x_q + dx;
        y_q   <= y_q - dy;
        ang_q <= ang_q + atan_v;
      end else begin
        x_q   <= x_q - dx;
        y_q   <= y_q + dy;
        ang_q <= ang_q - atan_v;
      end
    end
  end

  // Round the angle to Q8 and the gyro product to a Q8 increment
  always_comb begin
    ang_rnd = ang_q + ANG_W'(128);
    acc_d   = zero_q ? '0 : ang_rnd[ANG_W-1:8];
    incr_d  = prod[FRAC_W+INCR_W-1:FRAC_W] + INCR_W'(prod[FRAC_W-1]);
  end

  // Shared serial multiplier: gyro times gain, then weight times angle error
  always_comb begin
    alpha     = weight_q[tcf_pkg::WEIGHT_W-1] ? tcf_pkg::WEIGHT_ONE : weight_q;
    mul_start = in_fire || mix_sel;
    if (mix_sel) begin
      mul_mcand = {{(MCAND_W-ACC_W){acc_q[ACC_W-1]}}, acc_q}
                - {{(MCAND_W-SUM_W){s_q[SUM_W-1]}}, s_q};
      mul_mplr  = {{(MPLR_W-tcf_pkg::WEIGHT_W){1'b0}}, alpha};
    end else begin
      mul_mcand = {{(MCAND_W-tcf_pkg::GAIN_W){1'b0}}, gain_q};
      mul_mplr  = {{(MPLR_W-SMP_W){in_data_i.gyro_y[SMP_W-1]}}, in_data_i.gyro_y};
    end
  end

  tcf_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (mul_mcand),
    .mplr_i  (mul_mplr),
    .prod_o  (prod),
    .stat_o  (mul_stat)
  );

  // New angle: s + round(alpha * (acc - s) / 2^16), saturated
  always_comb begin
    nv_wide = {prod[PROD_W-1], prod[PROD_W-1:FRAC_W]}
            + {{(NV_W-SUM_W){s_q[SUM_W-1]}}, s_q}
            + NV_W'(prod[FRAC_W-1]);
    if (nv_wide > tcf_pkg::NV_MAX) begin
      nv_sat = tcf_pkg::NV_MAX[FILT_W-1:0];
    end else if (nv_wide < tcf_pkg::NV_MIN) begin
      nv_sat = tcf_pkg::NV_MIN[FILT_W-1:0];
    end else begin
      nv_sat = nv_wide[FILT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_exit) begin
      incr_q <= incr_d;
      acc_q  <= acc_d;
    end
    if (sum_en) begin
      s_q <= {{(SUM_W-FILT_W){filt_q[FILT_W-1]}}, filt_q}
           + {{(SUM_W-INCR_W){incr_q[INCR_W-1]}}, incr_q};
    end
    if (fin_en) begin
      nv_q <= nv_sat;
    end
  end

  // Hysteresis classifier on the new angle
  always_comb begin
    thr_s = {{(FILT_W-tcf_pkg::THR_W-8){1'b0}}, thr_q, 8'd0};
    pos_d = pos_q;
    if (pos_q == tcf_pkg::POS_CENTER) begin
      if (nv_q > thr_s) begin
        pos_d = tcf_pkg::POS_RIGHT;
      end else if (nv_q < -thr_s) begin
        pos_d = tcf_pkg::POS_LEFT;
      end
    end else if ((nv_q > -thr_s) && (nv_q < thr_s)) begin
      pos_d = tcf_pkg::POS_CENTER;
    end
  end

  // Commit the state and hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q      <= '0;
      pos_q       <= tcf_pkg::POS_CENTER;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        filt_q      <= nv_q;
        pos_q       <= pos_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.tilt_angle <= nv_q;
      out_q.position   <= pos_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_mul_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier restarted while busy");

  a_cordic_done_on_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_exit |-> (cstep_q == STEP_W'(CORDIC_STEPS)) && mul_stat.done)
    else $error("left the rotation phase early");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_state_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tcf_pkg::ST_OUT) |=> $stable(filt_q) && $stable(pos_q))
    else $error("filter state changed outside commit");

endmodule

/* tb/tcf_checker.sv */
`timescale 1ns / 1ps

module tcf_checker
  import tcf_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_t                   in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_t                  out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  // Mirror of the block's registers and filter state
  logic [WEIGHT_W-1:0]      weight;
  logic [GAIN_W-1:0]        gain;
  logic [THR_W-1:0]         thr_deg;
  logic signed [FILT_W-1:0] filt_angle;
  pos_e                     cur_pos;

  // Angle and position still owed by the block, oldest first
  out_t tilt_q [$];
  int   mismatches;
  out_t want;
  out_t nxt;

  // atan(2^-i) in Q16 degrees
  longint atan_deg_q16 [24];

  initial begin
    atan_deg_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                     14668, 7334, 3667, 1833, 917, 458, 229, 115,
                     57, 29, 14, 7, 4, 2, 1, 0};
  end

  // Work out the next filtered angle and position for one sample
  function automatic out_t predict_tilt(in_t s);
    longint x;
    longint y;
    longint phi;
    longint dx;
    longint dy;
    longint accel_q8;
    longint gyro_q8;
    longint wt;
    longint total;
    longint nv;
    longint thr;
    int     i;
    pos_e   pos;
    out_t   r;
    // Accelerometer tilt: vectoring CORDIC, pre-rotated for negative Z
    if (s.accel_x == 0 && s.accel_z == 0) begin
      accel_q8 = 0;
    end else begin
      if (s.accel_z >= 0) begin
        x = longint'(s.accel_z);
        y = longint'(s.accel_x);
        phi = 0;
      end else if (s.accel_x >= 0) begin
        x = longint'(s.accel_x);
        y = -longint'(s.accel_z);
        phi = 90 * 65536;
      end else begin
        x = -longint'(s.accel_x);
        y = longint'(s.accel_z);
        phi = -90 * 65536;
      end
      for (i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          phi = phi + atan_deg_q16[i];
        end else begin
          x = x - dx;
          y = y + dy;
          phi = phi - atan_deg_q16[i];
        end
      end
      accel_q8 = (phi + 128) >>> 8;
    end

    // Gyro increment, then the weighted blend with rounding half up
    gyro_q8 = (longint'(s.gyro_y) * longint'(gain) + 32768) >>> 16;
    wt = (weight > WEIGHT_ONE) ? 65536 : longint'(weight);
    total = wt * accel_q8 + (65536 - wt) * (longint'(filt_angle) + gyro_q8);
    nv = (total + 32768) >>> 16;
    if (nv > 8388607) nv = 8388607;
    if (nv < -8388608) nv = -8388608;

    // Hysteresis: leave a side only strictly inside both thresholds
    thr = longint'(thr_deg) * 256;
    pos = cur_pos;
    if (cur_pos == POS_CENTER) begin
      if (nv > thr) pos = POS_RIGHT;
      else if (nv < -thr) pos = POS_LEFT;
    end else if (nv > -thr && nv < thr) begin
      pos = POS_CENTER;
    end
    r.tilt_angle = FILT_W'(nv);
    r.position   = pos;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight     <= WEIGHT_RST;
      gain       <= GAIN_RST;
      thr_deg    <= THR_RST;
      filt_angle <= '0;
      cur_pos    <= POS_CENTER;
      tilt_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Compare each result transfer with the oldest owed result
      if (out_valid_i && out_ready_i) begin
        if (tilt_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got angle %0d position %0d",
                   $time, out_data_i.tilt_angle, out_data_i.position);
        end else begin
          want = tilt_q.pop_front();
          if (out_data_i.tilt_angle !== want.tilt_angle) begin
            mismatches++;
            $display("%0t: tilt_angle mismatch, expected %0d, got %0d",
                     $time, want.tilt_angle, out_data_i.tilt_angle);
          end
          if (out_data_i.position !== want.position) begin
            mismatches++;
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, want.position, out_data_i.position);
          end
        end
      end

      // Advance the filter state on each sample transfer
      if (in_valid_i && in_ready_i) begin
        nxt = predict_tilt(in_data_i);
        tilt_q.push_back(nxt);
        filt_angle <= nxt.tilt_angle;
        cur_pos    <= pos_e'(nxt.position);
      end

      // Register writes; an unknown index is dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ACCEL_WEIGHT: weight  <= cfg_data_i[WEIGHT_W-1:0];
          CFG_GYRO_GAIN:    gain    <= cfg_data_i[GAIN_W-1:0];
          CFG_THRESHOLD:    thr_deg <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end

      fail_count_o <= mismatches;
      pending_o    <= tilt_q.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tcf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int PHASES          = 8;
  localparam int PHASE_SAMPLES   = 140;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES     = 100;
  localparam int TIMEOUT_NS      = 2000000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  int mismatches;
  int pending;
  int ph;

  tilt_complementary_filter_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  tcf_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one sample after a random idle stretch; return on its transfer
  task automatic send_sample(input in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering and wait until every owed result has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Write all three registers, plus a write to the unused index
  task automatic set_regs(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] g,
                          input logic [CFG_DATA_W-1:0] t);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    int k;
    idx[0] = CFG_ACCEL_WEIGHT;
    idx[1] = CFG_GYRO_GAIN;
    idx[2] = CFG_THRESHOLD;
    idx[3] = CFG_SPARE;
    val[0] = w;
    val[1] = g;
    val[2] = t;
    val[3] = CFG_DATA_W'($urandom);
    for (k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Full-range samples, with zero axes and small gyro rates mixed in
  function automatic in_t rand_sample();
    in_t s;
    s.accel_x = SMP_W'($urandom);
    s.accel_z = SMP_W'($urandom);
    s.gyro_y  = SMP_W'($urandom);
    case ($urandom_range(9))
      0: s.accel_x = '0;
      1: s.accel_z = '0;
      2: begin
        s.accel_x = '0;
        s.accel_z = '0;
      end
      3, 4: s.gyro_y = {{8{s.gyro_y[7]}}, s.gyro_y[7:0]};
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] g;
    logic [CFG_DATA_W-1:0] t;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 65;

    // Reset settings: zero vector, axis extremes, straight down
    send_sample(in_t'{16'h0000, 16'h0000, 16'h0000});
    send_sample(in_t'{16'h0000, 16'h8000, 16'h0000});
    send_sample(in_t'{16'h0000, 16'hFFFF, 16'h0000});
    send_sample(in_t'{16'h7FFF, 16'h0000, 16'h7FFF});
    send_sample(in_t'{16'h8000, 16'h0000, 16'h8000});
    send_sample(in_t'{16'h7FFF, 16'h8000, 16'h0001});
    send_sample(in_t'{16'h8000, 16'h8000, 16'hFFFF});
    send_sample(in_t'{16'h8000, 16'h7FFF, 16'h0000});
    send_sample(in_t'{16'hFFFF, 16'hFFFF, 16'h0000});
    send_sample(in_t'{16'h7FFF, 16'h7FFF, 16'h7FFF});

    // Weight above one, no gyro, zero threshold: sides never return
    drain();
    set_regs(24'hFFFFFF, 24'h000000, 24'h000000);
    send_sample(in_t'{16'h0000, 16'h0000, 16'h1234});
    send_sample(in_t'{16'h0001, 16'h7FFF, 16'h0000});
    send_sample(in_t'{16'h0000, 16'h0000, 16'h0000});
    send_sample(in_t'{16'h8000, 16'h0001, 16'h0000});

    // Gyro only at full gain, threshold above range: drive both rails
    drain();
    set_regs(24'h000000, 24'hFFFFFF, 24'h0000FF);
    send_sample(in_t'{16'h7FFF, 16'h0000, 16'h7FFF});
    send_sample(in_t'{16'h0000, 16'h0000, 16'h7FFF});
    send_sample(in_t'{16'h0000, 16'h0000, 16'h7FFF});
    send_sample(in_t'{16'h0000, 16'h0000, 16'h8000});
    send_sample(in_t'{16'h0000, 16'h0000, 16'h8000});
    send_sample(in_t'{16'h0000, 16'h0000, 16'h8000});

    // Exactly one, top threshold
    drain();
    set_regs(24'h010000, 24'h000001, 24'd180);
    send_sample(in_t'{16'h0000, 16'h8000, 16'h0000});
    send_sample(in_t'{16'h8000, 16'h8000, 16'h0000});
    send_sample(in_t'{16'h0000, 16'h0000, 16'h0000});

    // Random phases, each under fresh register values
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 27;
        recv_idle_pct = 65;
      end else if (ph < 6) begin
        send_idle_pct = 65;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(3))
        0: w = 24'h000000;
        1: w = 24'h010000;
        2: w = CFG_DATA_W'($urandom);
        default: w = CFG_DATA_W'($urandom_range(0, 16384));
      endcase
      case ($urandom_range(2))
        0: g = CFG_DATA_W'($urandom);
        1: g = CFG_DATA_W'($urandom_range(0, 1 << 17));
        default: g = 24'h000000;
      endcase
      t = CFG_DATA_W'($urandom_range(1) ? $urandom_range(0, 255) : $urandom_range(0, 30));
      drain();
      set_regs(w, g, t);
      // Hold the result side off while samples keep coming
      if (ph == 6) hold_req = 1'b1;
      repeat (PHASE_SAMPLES) send_sample(rand_sample());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
